[design/route_forward_with_queue_drop_macros.svh]
// Assertion helpers for the forwarding engine checker.
// Both macros expect clk and arst_n in scope.
`ifndef ROUTE_FORWARD_WITH_QUEUE_DROP_MACROS_SVH
`define ROUTE_FORWARD_WITH_QUEUE_DROP_MACROS_SVH

// same-cycle implication
`define RFQD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFQD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rfqd_pkg.sv]
`timescale 1ns / 1ps

package rfqd_pkg;

	localparam int NUM_NODES_DEF = 64;

	// field widths
	localparam int OP_W     = 2;
	localparam int NODE_W   = 7;
	localparam int TTL_W    = 8;
	localparam int BYTES_W  = 16;
	localparam int NH_W     = 6;
	localparam int IF_W     = 8;
	localparam int STATUS_W = 3;
	localparam int QLEN_W   = 16;
	localparam int QUEUED_W = 32;
	localparam int USED_W   = 40;
	localparam int THR_W    = 16;

	// APB
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_THR_IDX = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = 16'd64;

	// ops
	localparam logic [OP_W-1:0] OP_ROUTE_WR = 2'd0;
	localparam logic [OP_W-1:0] OP_LINK_WR  = 2'd1;
	localparam logic [OP_W-1:0] OP_FWD      = 2'd2;
	localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_FWD      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TTL_DROP = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_LINK  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_Q_FULL   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

	localparam logic [TTL_W-1:0] TTL_EXPIRE = 8'd1;

	// queue length = queued / 1200, done as ((queued >> 4) * ceil(2^30 / 75)) >> 30,
	// exact for inputs below the saturation limit
	localparam int AVG_PACKET_BYTES = 1200;
	localparam logic [QUEUED_W-1:0] DIV_SAT_LIMIT = QUEUED_W'(65536 * AVG_PACKET_BYTES);
	localparam int DIV_PRE_SHIFT  = 4;
	localparam int DIV_IN_W       = 23;
	localparam int DIV_RECIP_W    = 24;
	localparam int DIV_PROD_W     = DIV_IN_W + DIV_RECIP_W;
	localparam int DIV_POST_SHIFT = 30;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 24'd14316558;

	typedef struct packed {
		logic            valid;
		logic [NH_W-1:0] next_node;
		logic [IF_W-1:0] out_if;
		logic [IF_W-1:0] next_if;
	} route_t;

	typedef struct packed {
		logic                present;
		logic [QUEUED_W-1:0] queued;
		logic [USED_W-1:0]   used;
		logic [QLEN_W-1:0]   qlen;
	} link_t;

	localparam int ROUTE_W = $bits(route_t);
	localparam int LINK_W  = $bits(link_t);

endpackage

[design/route_forward_with_queue_drop.sv]
// Forwarding engine: route table and link counters live in two RAMs with registered reads.
// A forward reads the route, then the link entry of its next hop, then decides and charges;
//   a slot tick walks the links, skipping absent ones, and drains, divides and writes back present ones.
// Throughput: one transaction at a time; next one taken the cycle after its result registers.
// Reset: async, active low; then a clearing pass over all NUM_NODES entries zeroes both RAMs
//   (req_ready low meanwhile, APB writes still taken). Threshold resets to 64.
`timescale 1ns / 1ps

module route_forward_with_queue_drop #(
	parameter int NUM_NODES = rfqd_pkg::NUM_NODES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB config
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rfqd_pkg::PADDR_W-1:0]       paddr,
	input  logic [rfqd_pkg::PDATA_W-1:0]       pwdata,
	output logic [rfqd_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	// request channel
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [rfqd_pkg::OP_W-1:0]          op,
	input  logic [rfqd_pkg::NODE_W-1:0]        node_index,
	input  logic [rfqd_pkg::TTL_W-1:0]         ttl,
	input  logic [rfqd_pkg::BYTES_W-1:0]       packet_bytes,
	input  logic                               packet_present,
	input  logic                               route_valid,
	input  logic [rfqd_pkg::NH_W-1:0]          route_next_node,
	input  logic [rfqd_pkg::IF_W-1:0]          route_out_if,
	input  logic [rfqd_pkg::IF_W-1:0]          route_next_if,
	input  logic                               link_present,
	// response channel
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [rfqd_pkg::STATUS_W-1:0]      status,
	output logic [rfqd_pkg::NH_W-1:0]          next_node,
	output logic [rfqd_pkg::IF_W-1:0]          out_if,
	output logic [rfqd_pkg::IF_W-1:0]          next_if,
	output logic                               reaches_destination,
	output logic [rfqd_pkg::QLEN_W-1:0]        queue_length_seen
);
	import rfqd_pkg::*;

	localparam int AW = $clog2(NUM_NODES);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_NODES - 1);

	// sequencer states
	localparam logic [3:0] S_CLR  = 4'd0;  // post-reset RAM clear
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_EXEC = 4'd2;  // op dispatch, table writes, route read
	localparam logic [3:0] S_RTE  = 4'd3;  // route data back, link read
	localparam logic [3:0] S_LNK  = 4'd4;  // link data back, decide, charge
	localparam logic [3:0] S_TRD  = 4'd5;  // tick: read link
	localparam logic [3:0] S_TSUB = 4'd6;  // tick: drain
	localparam logic [3:0] S_TMUL = 4'd7;  // tick: queue length multiply
	localparam logic [3:0] S_TWR  = 4'd8;  // tick: write back
	localparam logic [3:0] S_DONE = 4'd9;  // hand result to output register

	logic [3:0]        state_q;
	logic [AW-1:0]     idx_q;          // clear / tick walk pointer
	logic [THR_W-1:0]  thr_q;
	logic              rsp_valid_q;

	// captured transaction
	logic [OP_W-1:0]    op_q;
	logic [NODE_W-1:0]  node_q;
	logic [TTL_W-1:0]   ttl_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               pkt_q;
	logic               rv_q;
	logic [NH_W-1:0]    rnn_q;
	logic [IF_W-1:0]    roif_q;
	logic [IF_W-1:0]    rnif_q;
	logic               lp_q;

	// forward path
	route_t             rte_q;
	logic [AW-1:0]      lnk_addr_q;
	logic               nn_ok_q;

	// tick path
	logic [QUEUED_W-1:0]   tq_q;
	logic                  sat_q;
	logic [DIV_PROD_W-1:0] prod_q;

	// pending result and output register
	logic [STATUS_W-1:0] res_status_q;
	logic [NH_W-1:0]     res_nn_q;
	logic [IF_W-1:0]     res_oif_q;
	logic [IF_W-1:0]     res_nif_q;
	logic                res_arrive_q;
	logic [QLEN_W-1:0]   res_qseen_q;
	logic [STATUS_W-1:0] status_q;
	logic [NH_W-1:0]     nn_q;
	logic [IF_W-1:0]     oif_q;
	logic [IF_W-1:0]     nif_q;
	logic                arrive_q;
	logic [QLEN_W-1:0]   qseen_q;

	// RAM ports
	logic          rte_we, rte_re;
	logic [AW-1:0] rte_waddr, rte_raddr;
	route_t        rte_wdata, rte_rdata;
	logic          lnk_we, lnk_re;
	logic [AW-1:0] lnk_waddr, lnk_raddr;
	link_t         lnk_wdata, lnk_rdata;

	link_t               lnk_charged;
	logic [QUEUED_W-1:0] lnk_drained;

	logic              req_fire;
	logic              out_free;
	logic              node_ok;
	logic              have_link;
	logic              fwd_ok;
	logic [STATUS_W-1:0] dec_status;
	logic              cfg_wr;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign node_ok   = 32'(node_q) < NUM_NODES;

	// ---- APB: single threshold register, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THR_IDX);
	assign prdata = (paddr[2] == REG_THR_IDX) ? PDATA_W'(thr_q) : '0;

	// ---- forward decision on the link entry just read
	// order of checks: TTL, absent link, queue full
	always_comb begin
		have_link = nn_ok_q && lnk_rdata.present;
		fwd_ok    = 1'b0;
		if (ttl_q == TTL_EXPIRE) begin
			dec_status = ST_TTL_DROP;
		end else if (!have_link) begin
			dec_status = ST_NO_LINK;
		end else if (lnk_rdata.qlen >= thr_q) begin
			dec_status = ST_Q_FULL;
		end else begin
			dec_status = ST_FWD;
			fwd_ok     = 1'b1;
		end
	end

	// ---- RAM port muxing
	always_comb begin
		rte_we    = 1'b0;
		rte_waddr = '0;
		rte_wdata = '0;
		rte_re    = 1'b0;
		rte_raddr = '0;
		lnk_we    = 1'b0;
		lnk_waddr = '0;
		lnk_wdata = '0;
		lnk_re    = 1'b0;
		lnk_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				rte_we    = 1'b1;
				rte_waddr = idx_q;
				lnk_we    = 1'b1;
				lnk_waddr = idx_q;
			end
			S_EXEC: begin
				unique case (op_q)
					OP_ROUTE_WR: begin
						rte_we    = node_ok;
						rte_waddr = AW'(node_q);
						rte_wdata = '{valid: rv_q, next_node: rnn_q,
							out_if: roif_q, next_if: rnif_q};
					end
					OP_LINK_WR: begin
						// presence write also clears the counters
						lnk_we            = node_ok;
						lnk_waddr         = AW'(node_q);
						lnk_wdata.present = lp_q;
					end
					OP_FWD: begin
						rte_re    = node_ok;
						rte_raddr = AW'(node_q);
					end
					OP_TICK: begin
					end
					default: begin
					end
				endcase
			end
			S_RTE: begin
				lnk_re    = 1'b1;
				lnk_raddr = AW'(rte_rdata.next_node);
			end
			S_LNK: begin
				lnk_we    = fwd_ok && pkt_q;
				lnk_waddr = lnk_addr_q;
				lnk_wdata = lnk_charged;
			end
			S_TRD: begin
				lnk_re    = 1'b1;
				lnk_raddr = idx_q;
			end
			S_TWR: begin
				lnk_we            = 1'b1;
				lnk_waddr         = idx_q;
				lnk_wdata.present = 1'b1;
				lnk_wdata.queued  = tq_q;
				lnk_wdata.used    = '0;
				lnk_wdata.qlen    = sat_q ? {QLEN_W{1'b1}}
					: prod_q[DIV_POST_SHIFT +: QLEN_W];
			end
			default: begin
			end
		endcase
	end

	rfqd_ram #(.WIDTH(ROUTE_W), .DEPTH(NUM_NODES)) u_route_ram (
		.clk   (clk),
		.we    (rte_we),
		.waddr (rte_waddr),
		.wdata (rte_wdata),
		.re    (rte_re),
		.raddr (rte_raddr),
		.rdata (rte_rdata)
	);

	rfqd_ram #(.WIDTH(LINK_W), .DEPTH(NUM_NODES)) u_link_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.re    (lnk_re),
		.raddr (lnk_raddr),
		.rdata (lnk_rdata)
	);

	rfqd_link_upd u_link_upd (
		.cur     (lnk_rdata),
		.bytes   (bytes_q),
		.charged (lnk_charged),
		.drained (lnk_drained)
	);

	// ---- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			idx_q       <= '0;
			thr_q       <= THR_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				thr_q <= pwdata[THR_W-1:0];
			end

			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						OP_FWD:  state_q <= node_ok ? S_RTE : S_DONE;
						OP_TICK: state_q <= S_TRD;
						default: state_q <= S_DONE;
					endcase
				end
				S_RTE: begin
					state_q <= rte_rdata.valid ? S_LNK : S_DONE;
				end
				S_LNK: begin
					state_q <= S_DONE;
				end
				S_TRD: begin
					state_q <= S_TSUB;
				end
				S_TSUB: begin
					// absent links are left untouched
					if (lnk_rdata.present) begin
						state_q <= S_TMUL;
					end else if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_TRD;
					end
				end
				S_TMUL: begin
					state_q <= S_TWR;
				end
				S_TWR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_TRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---- datapath registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q    <= op;
			node_q  <= node_index;
			ttl_q   <= ttl;
			bytes_q <= packet_bytes;
			pkt_q   <= packet_present;
			rv_q    <= route_valid;
			rnn_q   <= route_next_node;
			roif_q  <= route_out_if;
			rnif_q  <= route_next_if;
			lp_q    <= link_present;
		end

		if (state_q == S_EXEC) begin
			res_status_q <= (op_q == OP_FWD) ? ST_NO_ROUTE : ST_DONE;
			res_nn_q     <= '0;
			res_oif_q    <= '0;
			res_nif_q    <= '0;
			res_arrive_q <= 1'b0;
			res_qseen_q  <= '0;
		end

		if (state_q == S_RTE) begin
			rte_q      <= rte_rdata;
			lnk_addr_q <= AW'(rte_rdata.next_node);
			nn_ok_q    <= 32'(rte_rdata.next_node) < NUM_NODES;
		end

		if (state_q == S_LNK) begin
			res_status_q <= dec_status;
			res_qseen_q  <= have_link ? lnk_rdata.qlen : '0;
			if (fwd_ok) begin
				res_nn_q     <= rte_q.next_node;
				res_oif_q    <= rte_q.out_if;
				res_nif_q    <= rte_q.next_if;
				res_arrive_q <= ({1'b0, rte_q.next_node} == node_q);
			end
		end

		if (state_q == S_TSUB) begin
			tq_q <= lnk_drained;
		end

		// registered multiply by the reciprocal of 75 (after >> 4)
		if (state_q == S_TMUL) begin
			sat_q  <= tq_q >= DIV_SAT_LIMIT;
			prod_q <= DIV_PROD_W'(tq_q[DIV_PRE_SHIFT +: DIV_IN_W])
				* DIV_PROD_W'(DIV_RECIP);
		end

		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			nn_q     <= res_nn_q;
			oif_q    <= res_oif_q;
			nif_q    <= res_nif_q;
			arrive_q <= res_arrive_q;
			qseen_q  <= res_qseen_q;
		end
	end

	assign rsp_valid           = rsp_valid_q;
	assign status              = status_q;
	assign next_node           = nn_q;
	assign out_if              = oif_q;
	assign next_if             = nif_q;
	assign reaches_destination = arrive_q;
	assign queue_length_seen   = qseen_q;

endmodule

[design/rfqd_ram.sv]
`timescale 1ns / 1ps

module rfqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/rfqd_link_upd.sv]
`timescale 1ns / 1ps

module rfqd_link_upd (
	input  rfqd_pkg::link_t                     cur,
	input  logic [rfqd_pkg::BYTES_W-1:0]        bytes,
	output rfqd_pkg::link_t                     charged,
	output logic [rfqd_pkg::QUEUED_W-1:0]       drained
);
	import rfqd_pkg::*;

	logic [USED_W:0]     used_sum;
	logic [QUEUED_W:0]   queued_sum;
	logic [USED_W-4:0]   drain;

	// charge one packet, all counters saturate
	always_comb begin
		used_sum   = {1'b0, cur.used} + (USED_W + 1)'({bytes, 3'b000});
		queued_sum = {1'b0, cur.queued} + (QUEUED_W + 1)'(bytes);
		charged.present = cur.present;
		charged.used    = used_sum[USED_W] ? {USED_W{1'b1}} : used_sum[USED_W-1:0];
		charged.queued  = queued_sum[QUEUED_W] ? {QUEUED_W{1'b1}} : queued_sum[QUEUED_W-1:0];
		charged.qlen    = (&cur.qlen) ? cur.qlen : cur.qlen + QLEN_W'(1);
	end

	// slot drain: used bits / 8, floored at zero
	always_comb begin
		drain = cur.used[USED_W-1:3];
		if ((USED_W - 3)'(cur.queued) > drain) begin
			drained = cur.queued - drain[QUEUED_W-1:0];
		end else begin
			drained = '0;
		end
	end

endmodule

[design/rfqd_checker.sv]
`timescale 1ns / 1ps
`include "route_forward_with_queue_drop_macros.svh"

module rfqd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic [rfqd_pkg::STATUS_W-1:0]      status,
	input logic [rfqd_pkg::NH_W-1:0]          next_node,
	input logic [rfqd_pkg::IF_W-1:0]          out_if,
	input logic [rfqd_pkg::IF_W-1:0]          next_if,
	input logic                               reaches_destination,
	input logic [rfqd_pkg::QLEN_W-1:0]        queue_length_seen
);
	import rfqd_pkg::*;

	// stalled response holds
	`RFQD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(status) && $stable(queue_length_seen),
		"response changed while stalled")

	`RFQD_ASSERT_NOW(a_status_code, rsp_valid, status <= ST_DONE, "status code out of range")

	// hop fields only carry data on a forwarded packet
	`RFQD_ASSERT_NOW(a_hop_zero, rsp_valid && status != ST_FWD,
		next_node == '0 && out_if == '0 && next_if == '0 && !reaches_destination,
		"hop fields set on non-forward")

	`RFQD_ASSERT_NOW(a_qseen_zero,
		rsp_valid && (status == ST_NO_ROUTE || status == ST_NO_LINK || status == ST_DONE),
		queue_length_seen == '0, "queue length shown without a link")

	// one transaction in flight: ready drops after an accept
	`RFQD_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
		"request accepted back to back")

endmodule

bind route_forward_with_queue_drop rfqd_checker u_rfqd_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

import rfqd_pkg::*;

localparam int NODES = NUM_NODES_DEF;
localparam logic [PADDR_W-1:0] THR_ADDR = PADDR_W'(4 * int'(REG_THR_IDX));

typedef struct packed {
	logic [OP_W-1:0]    op;
	logic [NODE_W-1:0]  node_index;
	logic [TTL_W-1:0]   ttl;
	logic [BYTES_W-1:0] packet_bytes;
	logic               packet_present;
	logic               route_valid;
	logic [NH_W-1:0]    route_next_node;
	logic [IF_W-1:0]    route_out_if;
	logic [IF_W-1:0]    route_next_if;
	logic               link_present;
} fwd_req_t;

typedef struct packed {
	logic [STATUS_W-1:0] status;
	logic [NH_W-1:0]     next_node;
	logic [IF_W-1:0]     out_if;
	logic [IF_W-1:0]     next_if;
	logic                reaches_destination;
	logic [QLEN_W-1:0]   queue_length_seen;
} fwd_rsp_t;

// Shadow of the route table and link counters; queues the response each request should give.
class forwarding_checker;
	route_t              routes[NODES];
	bit                  link_up[NODES];
	logic [QUEUED_W-1:0] link_queued[NODES];
	logic [USED_W-1:0]   link_used[NODES];
	logic [QLEN_W-1:0]   link_qlen[NODES];
	logic [THR_W-1:0]    threshold;
	fwd_rsp_t            due_responses[$];
	int                  mismatches;
	int                  status_count[8];

	function new();
		threshold = THR_RESET;
		mismatches = 0;
		foreach (routes[n]) begin
			routes[n] = '0;
			link_up[n] = 1'b0;
			clear_link(n);
		end
		foreach (status_count[s])
			status_count[s] = 0;
	endfunction

	function void clear_link(int n);
		link_queued[n] = '0;
		link_used[n] = '0;
		link_qlen[n] = '0;
	endfunction

	// slot tick: drain each present link by the bytes it sent this slot
	function void drain_slot();
		longint unsigned drain, q;
		for (int n = 0; n < NODES; n++) begin
			if (!link_up[n])
				continue;
			drain = link_used[n] / 8;
			q = (link_queued[n] > drain) ? link_queued[n] - drain : 0;
			link_queued[n] = q[QUEUED_W-1:0];
			link_used[n] = '0;
			q = q / AVG_PACKET_BYTES;
			link_qlen[n] = (q > 64'hFFFF) ? '1 : q[QLEN_W-1:0];
		end
	endfunction

	function void charge_link(int n, logic [BYTES_W-1:0] bytes);
		longint unsigned v;
		v = link_used[n] + bytes * 64'd8;
		link_used[n] = (v > 64'hFF_FFFF_FFFF) ? '1 : v[USED_W-1:0];
		v = link_queued[n] + 64'(bytes);
		link_queued[n] = (v > 64'hFFFF_FFFF) ? '1 : v[QUEUED_W-1:0];
		if (link_qlen[n] != '1)
			link_qlen[n]++;
	endfunction

	function void note_request(fwd_req_t r);
		fwd_rsp_t e;
		route_t   rt;
		int       hop;
		bit       have;
		e = '0;
		e.status = ST_DONE;
		case (r.op)
			OP_ROUTE_WR: begin
				if (r.node_index < NODES)
					routes[r.node_index] = '{r.route_valid, r.route_next_node,
						r.route_out_if, r.route_next_if};
			end
			OP_LINK_WR: begin
				if (r.node_index < NODES) begin
					link_up[r.node_index] = r.link_present;
					clear_link(r.node_index);
				end
			end
			OP_TICK: drain_slot();
			default: begin
				if (r.node_index >= NODES || !routes[r.node_index].valid) begin
					e.status = ST_NO_ROUTE;
				end else begin
					rt = routes[r.node_index];
					hop = rt.next_node;
					have = (hop < NODES) && link_up[hop];
					if (have)
						e.queue_length_seen = link_qlen[hop];
					if (r.ttl == TTL_EXPIRE) begin
						e.status = ST_TTL_DROP;
					end else if (!have) begin
						e.status = ST_NO_LINK;
					end else if (link_qlen[hop] >= threshold) begin
						e.status = ST_Q_FULL;
					end else begin
						e.status = ST_FWD;
						if (r.packet_present)
							charge_link(hop, r.packet_bytes);
						e.next_node = rt.next_node;
						e.out_if = rt.out_if;
						e.next_if = rt.next_if;
						e.reaches_destination = (rt.next_node == r.node_index);
					end
				end
			end
		endcase
		status_count[e.status]++;
		due_responses = {due_responses, e};
	endfunction

	function void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	function void check_response(fwd_rsp_t got);
		fwd_rsp_t want;
		if (due_responses.size() == 0) begin
			$error("response with nothing outstanding (status %0d)", got.status);
			mismatches++;
			return;
		end
		want = due_responses.pop_front();
		compare_field("status", want.status, got.status);
		compare_field("next_node", want.next_node, got.next_node);
		compare_field("out_if", want.out_if, got.out_if);
		compare_field("next_if", want.next_if, got.next_if);
		compare_field("reaches_destination", want.reaches_destination,
			got.reaches_destination);
		compare_field("queue_length_seen", want.queue_length_seen, got.queue_length_seen);
	endfunction
endclass

module tb;
	// clock, reset, and every DUT input start at a known value
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [OP_W-1:0]     op = '0;
	logic [NODE_W-1:0]   node_index = '0;
	logic [TTL_W-1:0]    ttl = '0;
	logic [BYTES_W-1:0]  packet_bytes = '0;
	logic                packet_present = 1'b0;
	logic                route_valid = 1'b0;
	logic [NH_W-1:0]     route_next_node = '0;
	logic [IF_W-1:0]     route_out_if = '0;
	logic [IF_W-1:0]     route_next_if = '0;
	logic                link_present = 1'b0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [NH_W-1:0]     next_node;
	logic [IF_W-1:0]     out_if;
	logic [IF_W-1:0]     next_if;
	logic                reaches_destination;
	logic [QLEN_W-1:0]   queue_length_seen;

	// idle/stall odds in percent, changed per phase
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cfg_errors = 0;
	forwarding_checker sb;

	route_forward_with_queue_drop uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready),
		.op(op), .node_index(node_index), .ttl(ttl), .packet_bytes(packet_bytes),
		.packet_present(packet_present), .route_valid(route_valid),
		.route_next_node(route_next_node), .route_out_if(route_out_if),
		.route_next_if(route_next_if), .link_present(link_present),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .next_node(next_node), .out_if(out_if), .next_if(next_if),
		.reaches_destination(reaches_destination), .queue_length_seen(queue_length_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Response side: values sampled at the edge are the pre-edge ones, so a
	// transaction is taken when valid and ready were both high going into it.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response('{status, next_node, out_if, next_if,
				reaches_destination, queue_length_seen});
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// random fill for every field; callers override the ones that matter
	function automatic fwd_req_t noise_item();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[$bits(fwd_req_t)-1:0];
	endfunction

	function automatic fwd_req_t route_item(int node, bit valid, int hop, int oif, int nif);
		fwd_req_t r;
		r = noise_item();
		r.op = OP_ROUTE_WR;
		r.node_index = NODE_W'(node);
		r.route_valid = valid;
		r.route_next_node = NH_W'(hop);
		r.route_out_if = IF_W'(oif);
		r.route_next_if = IF_W'(nif);
		return r;
	endfunction

	function automatic fwd_req_t link_item(int node, bit present);
		fwd_req_t r;
		r = noise_item();
		r.op = OP_LINK_WR;
		r.node_index = NODE_W'(node);
		r.link_present = present;
		return r;
	endfunction

	function automatic fwd_req_t fwd_item(int node, int life, int bytes, bit pkt);
		fwd_req_t r;
		r = noise_item();
		r.op = OP_FWD;
		r.node_index = NODE_W'(node);
		r.ttl = TTL_W'(life);
		r.packet_bytes = BYTES_W'(bytes);
		r.packet_present = pkt;
		return r;
	endfunction

	function automatic fwd_req_t tick_item();
		fwd_req_t r;
		r = noise_item();
		r.op = OP_TICK;
		return r;
	endfunction

	// Mostly forwards onto a small hot set of destinations and links so that
	// routes, present links and queue lengths build up; the rest is table and
	// link churn, out-of-range nodes and the odd slot tick.
	function automatic fwd_req_t random_item();
		fwd_req_t r;
		int pick, sel;
		r = noise_item();
		pick = $urandom_range(99);
		sel = $urandom_range(99);
		if (pick < 70) begin
			r.op = OP_FWD;
			if (sel < 70)
				r.node_index = NODE_W'($urandom_range(15));
			else if (sel < 90)
				r.node_index = NODE_W'($urandom_range(NODES - 1));
			else
				r.node_index = NODE_W'($urandom_range(127, NODES));
			sel = $urandom_range(99);
			if (sel < 10)
				r.ttl = TTL_EXPIRE;
			else if (sel < 15)
				r.ttl = '0;
			r.packet_present = ($urandom_range(99) < 85);
			sel = $urandom_range(99);
			if (sel < 10)
				r.packet_bytes = '1;
			else if (sel < 15)
				r.packet_bytes = '0;
		end else if (pick < 82) begin
			r.op = OP_ROUTE_WR;
			if (sel < 85)
				r.node_index = NODE_W'($urandom_range(15));
			r.route_valid = ($urandom_range(99) < 85);
			if ($urandom_range(99) < 75)
				r.route_next_node = NH_W'($urandom_range(7));
		end else if (pick < 97) begin
			r.op = OP_LINK_WR;
			if (sel < 80)
				r.node_index = NODE_W'($urandom_range(7));
			r.link_present = ($urandom_range(99) < 80);
		end else begin
			r.op = OP_TICK;
		end
		return r;
	endfunction

	// Present one request; an idle gap (valid low) may come first. Returns at
	// the edge where the transaction was accepted.
	task automatic send_request(input fwd_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		op <= r.op;
		node_index <= r.node_index;
		ttl <= r.ttl;
		packet_bytes <= r.packet_bytes;
		packet_present <= r.packet_present;
		route_valid <= r.route_valid;
		route_next_node <= r.route_next_node;
		route_out_if <= r.route_out_if;
		route_next_if <= r.route_next_if;
		link_present <= r.link_present;
		do @(posedge clk); while (req_ready !== 1'b1);
		sb.note_request(r);
	endtask

	// every request gives exactly one response, so an empty queue means idle
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (sb.due_responses.size() != 0)
			@(posedge clk);
	endtask

	// APB write: setup then access; register takes the value at the access edge
	task automatic cfg_write(input logic [THR_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= THR_ADDR;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.threshold = value;
	endtask

	task automatic cfg_read_check(input logic [THR_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= THR_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== PDATA_W'(want)) begin
			$error("queue_drop_threshold mismatch: expected %0d, got %0d", want, prdata);
			cfg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : main
		logic [THR_W-1:0] thr_plan[6];
		sb = new();
		// 64 is the reset value; then both extremes and a few small ones that
		// make queue-full drops common
		thr_plan = '{16'd64, 16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd0};
		thr_plan[5] = THR_W'($urandom_range(12, 2));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_read_check(THR_RESET);

		// directed: threshold 2 so a full queue is reachable in a few packets
		cfg_write(16'd2);
		send_request(fwd_item(5, 64, 100, 1));        // empty table: no route
		send_request(fwd_item(127, 64, 100, 1));      // destination out of range
		send_request(route_item(127, 1, 3, 1, 1));    // out-of-range route write, ignored
		send_request(link_item(100, 1));              // out-of-range link write, ignored
		send_request(route_item(5, 1, 9, 255, 0));
		send_request(fwd_item(5, 1, 10, 1));          // TTL expiry, link absent
		send_request(fwd_item(5, 0, 10, 1));          // TTL zero passes, then no link
		send_request(link_item(9, 1));
		send_request(fwd_item(5, 0, 65535, 1));       // forwarded, max size
		send_request(fwd_item(5, 255, 500, 0));       // no packet: counters untouched
		send_request(fwd_item(5, 1, 10, 1));          // TTL drop shows queue length
		send_request(fwd_item(5, 2, 1, 1));           // length reaches threshold
		send_request(fwd_item(5, 3, 1, 1));           // queue full
		send_request(tick_item());                    // slot tick drains link 9
		send_request(fwd_item(5, 64, 0, 1));          // after slot tick: length back to 0
		send_request(route_item(9, 1, 9, 0, 255));
		send_request(fwd_item(9, 64, 1500, 1));       // next hop is the destination
		send_request(route_item(63, 1, 63, 255, 255));
		send_request(link_item(63, 1));
		send_request(fwd_item(63, 255, 65535, 1));    // top node, all-ones route
		send_request(route_item(0, 1, 0, 0, 0));
		send_request(link_item(0, 1));
		send_request(fwd_item(0, 128, 0, 1));         // bottom node, zero-byte packet
		send_request(link_item(9, 0));                // link removed
		send_request(fwd_item(5, 64, 64, 1));         // route still there: no link
		send_request(route_item(5, 0, 9, 1, 1));      // route invalidated
		send_request(fwd_item(5, 64, 64, 1));         // no route
		wait_idle();

		// random phases, cycling through the idling modes
		for (int p = 0; p < 6; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 46; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 46; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			cfg_write(thr_plan[p]);
			cfg_read_check(thr_plan[p]);
			repeat (300) send_request(random_item());
			wait_idle();
		end

		// longest single transaction is a slot tick
		repeat (300) @(posedge clk);

		$display("Ran %0d transactions over 6 thresholds and 4 idling modes.",
			sb.status_count[ST_FWD] + sb.status_count[ST_NO_ROUTE] +
			sb.status_count[ST_TTL_DROP] + sb.status_count[ST_NO_LINK] +
			sb.status_count[ST_Q_FULL] + sb.status_count[ST_DONE]);
		$display("Forwarded %0d, no route %0d, TTL drop %0d, no link %0d, queue full %0d, other %0d.",
			sb.status_count[ST_FWD], sb.status_count[ST_NO_ROUTE],
			sb.status_count[ST_TTL_DROP], sb.status_count[ST_NO_LINK],
			sb.status_count[ST_Q_FULL], sb.status_count[ST_DONE]);
		if (sb.mismatches == 0 && cfg_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hang guard: well above the slowest legal run
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
